// ===== rtl/core/url_enc_pkg.sv =====
// Shared constants, types and a helper function for the URL percent encoder.
`default_nettype none

package url_enc_pkg;

   // Character codes used by the encoder.
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] PERCENT_CHAR = 8'h25;
   localparam logic [7:0] PLUS_CHAR    = 8'h2B;
   localparam logic [7:0] DIGIT_ZERO   = 8'h30;
   localparam logic [7:0] LETTER_A     = 8'h41;
   localparam logic [7:0] NULL_CHAR    = 8'h00;

   // At most four characters come from one input byte.
   localparam int GROUP_MAX   = 4;
   localparam int COUNT_WIDTH = $clog2(GROUP_MAX + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_NONE    = COUNT_WIDTH'(0);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE     = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ESCAPE  = COUNT_WIDTH'(3);
   localparam logic [COUNT_WIDTH-1:0] COUNT_WITH_PLUS = COUNT_WIDTH'(4);

   // Characters for one input byte, first character in slot 0.
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] chars;
      logic [COUNT_WIDTH-1:0]    count;
   } char_group_type;

   // Upper-case hex digit for one nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] result;
      if (nibble < 4'd10) begin
         result = DIGIT_ZERO + {4'b0000, nibble};
      end else begin
         result = LETTER_A + {4'b0000, nibble - 4'd10};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/url_enc_core.sv =====
// Encoder core: word/plus state and the character group for one byte.
`default_nettype none

module url_enc_core
   import url_enc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [7:0]     text_byte,
   input  wire logic           end_of_text,
   input  wire logic           advance,
   output char_group_type      group
);

   logic word_emitted_ff;
   logic word_emitted_in;
   logic plus_pending_ff;
   logic plus_pending_in;
   logic is_space;
   logic send_plus;
   logic [7:0] hi_char;
   logic [7:0] lo_char;

   assign is_space  = (text_byte == SPACE_CHAR);
   assign send_plus = plus_pending_ff && word_emitted_ff;
   assign hi_char   = hex_digit(text_byte[7:4]);
   assign lo_char   = hex_digit(text_byte[3:0]);

   // Character group for the byte in the input register.
   always_comb begin
      if (is_space) begin
         group.chars = {NULL_CHAR, NULL_CHAR, NULL_CHAR, NULL_CHAR};
         group.count = COUNT_NONE;
      end else if (send_plus) begin
         group.chars = {lo_char, hi_char, PERCENT_CHAR, PLUS_CHAR};
         group.count = COUNT_WITH_PLUS;
      end else begin
         group.chars = {NULL_CHAR, lo_char, hi_char, PERCENT_CHAR};
         group.count = COUNT_ESCAPE;
      end
   end

   // State update once the byte has been handed on; end of text clears both.
   always_comb begin
      word_emitted_in = word_emitted_ff;
      plus_pending_in = plus_pending_ff;
      if (advance) begin
         if (end_of_text) begin
            word_emitted_in = 1'b0;
            plus_pending_in = 1'b0;
         end else if (is_space) begin
            plus_pending_in = plus_pending_ff | word_emitted_ff;
         end else begin
            word_emitted_in = 1'b1;
            plus_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_emitted_ff <= 1'b0;
         plus_pending_ff <= 1'b0;
      end else begin
         word_emitted_ff <= word_emitted_in;
         plus_pending_ff <= plus_pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/url_enc_ser.sv =====
// Output serializer: sends a character group one character per item.
`default_nettype none

module url_enc_ser
   import url_enc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  wire char_group_type group,
   output logic                free,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] out_char
   output logic                rsp_tlast    // run_last
);

   logic [GROUP_MAX-1:0][7:0] chars_ff;
   logic [GROUP_MAX-1:0][7:0] chars_in;
   logic [COUNT_WIDTH-1:0]    remain_ff;
   logic [COUNT_WIDTH-1:0]    remain_in;
   logic                      rsp_take;

   assign rsp_tvalid = (remain_ff != COUNT_NONE);
   assign rsp_tdata  = chars_ff[0];
   assign rsp_tlast  = (remain_ff == COUNT_ONE);
   assign rsp_take   = rsp_tvalid && rsp_tready;

   // A new group may load when empty or when the last character leaves now.
   assign free = (remain_ff == COUNT_NONE) || (rsp_tlast && rsp_tready);

   // Load a group or shift the next character to the front.
   always_comb begin
      chars_in  = chars_ff;
      remain_in = remain_ff;
      if (load) begin
         chars_in  = group.chars;
         remain_in = group.count;
      end else if (rsp_take) begin
         chars_in  = {NULL_CHAR, chars_ff[GROUP_MAX-1:1]};
         remain_in = remain_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      if (reset) begin
         remain_ff <= COUNT_NONE;
      end else begin
         remain_ff <= remain_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/url_percent_encoder.sv =====
// Top level of the form-style URL percent encoder.
//
// The req channel takes one text byte per item in tdata, with tlast set on
// the last byte of a text. The rsp channel gives one character per item in
// tdata; tlast marks the last character caused by one input byte.
// Each byte other than a space gives '%' and two upper-case hex digits,
// preceded by '+' when a run of spaces separated it from an earlier word.
// Spaces give no output; end of text forgets any pending '+'.
// An accepted byte sits in an input register, is encoded there and, once the
// serializer is free, loaded into the output serializer. The first character
// goes out on rsp from the serializer register, which follows the input register.
// An escaped byte occupies the serializer while its three or four characters
// go out; a space is handed on without waiting for the serializer.
// The next byte is taken while the current characters are still going out.
// Reset empties both registers and clears the word and plus state.
// When the receiver stalls, the current character holds and, once the input
// register is full, req_tready falls.
`default_nettype none

module url_percent_encoder
   import url_enc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_char
   output logic             rsp_tlast    // run_last
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_end_ff;
   logic           in_take;
   logic           ser_free;
   logic           ser_load;
   char_group_type group;

   // Encode the registered byte.
   url_enc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .text_byte   (in_byte_ff),
      .end_of_text (in_end_ff),
      .advance     (in_take),
      .group       (group)
   );

   // Hand the byte on when it has no characters or the serializer is free.
   assign in_take    = in_valid_ff && ((group.count == COUNT_NONE) || ser_free);
   assign ser_load   = in_take && (group.count != COUNT_NONE);
   assign req_tready = !in_valid_ff || in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Serialize the characters onto the result channel.
   url_enc_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .load       (ser_load),
      .group      (group),
      .free       (ser_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
